// ----- rtl/binary_popcount_linear_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the binary popcount linear block
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_POPCOUNT_LINEAR_MACROS_SVH
`define BINARY_POPCOUNT_LINEAR_MACROS_SVH

// condition implies consequence in the same cycle
`define BPL_ASSERT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("bpl assertion failed");

// condition implies consequence in the next cycle
`define BPL_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("bpl assertion failed");

`endif

// ----- rtl/bpl_pkg.sv -----
// ----------------------------------------------------------------------------
// bpl_pkg
// Types, constants and helpers shared by the binary popcount linear block.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_WORDS_DEF = 64;
    localparam int OUT_LIMIT     = 64;
    localparam int WORD_W        = 64;
    localparam int ROW_W         = 6;
    localparam int IDX_W         = 6;
    localparam int K_W           = 13;
    localparam int N_W           = 7;
    localparam int CFG_W         = 13;
    localparam int DOT_W         = 14;
    localparam int POP_W         = 7;
    localparam int ACC_MAX       = 8191;
    localparam int BITS_RESET    = 4096;
    localparam int ROWS_RESET    = 64;
    localparam int CMD_DEPTH     = 2;
    localparam int CMD_PW        = $clog2(CMD_DEPTH);
    localparam int CMD_CW        = $clog2(CMD_DEPTH + 1);

    typedef enum logic
    {
        REG_BITS = 1'b0,
        REG_ROWS = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        FUNC_LOAD = 1'b0,
        FUNC_ACT  = 1'b1
    } func_t;

    typedef struct packed
    {
        logic              func;
        logic [ROW_W-1:0]  weight_row;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] data_word;
    } in_t;

    typedef struct packed
    {
        logic signed [DOT_W-1:0] dot_value;
        logic [ROW_W-1:0]        out_row;
        logic                    last;
    } res_t;

    // classified item handed from front to back
    typedef struct packed
    {
        func_t             kind;
        logic              first;
        logic              closing;
        logic [ROW_W-1:0]  row;
        logic [IDX_W-1:0]  widx;
        logic [WORD_W-1:0] data;
    } cmd_t;

    // byte counts first, then their sum
    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
        logic [3:0]       part [8];
        logic [POP_W-1:0] sum;
        sum = '0;
        for (int b = 0; b < 8; b++)
        begin
            part[b] = '0;
            for (int i = 0; i < 8; i++)
            begin
                part[b] = part[b] + 4'(x[8*b+i]);
            end
        end
        for (int b = 0; b < 8; b++)
        begin
            sum = sum + POP_W'(part[b]);
        end
        return sum;
    endfunction

endpackage

// ----- rtl/bpl_front.sv -----
// ----------------------------------------------------------------------------
// bpl_front
// Accepts items, drops out-of-range words, tags row start and row end, and
// queues the rest for the back end.
// ----------------------------------------------------------------------------
module bpl_front #(
    parameter int MAX_ROWS  = bpl_pkg::MAX_ROWS_DEF,
    parameter int MAX_WORDS = bpl_pkg::MAX_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  bpl_pkg::in_t             in_item,
    input  logic [bpl_pkg::N_W-1:0]  words,
    output logic                     cmd_valid,
    input  logic                     cmd_pop,
    output bpl_pkg::cmd_t            cmd
);

    bpl_pkg::cmd_t                q_reg [bpl_pkg::CMD_DEPTH];
    logic [bpl_pkg::CMD_PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [bpl_pkg::CMD_PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [bpl_pkg::CMD_CW-1:0]   cnt_reg, cnt_next;
    logic                         keep;
    logic                         do_wr;
    logic                         do_rd;
    bpl_pkg::cmd_t                new_cmd;

    always_comb
    begin
        if (in_item.func == bpl_pkg::FUNC_LOAD)
        begin
            keep = (int'(in_item.weight_row) < MAX_ROWS) &&
                   (int'(in_item.word_index) < MAX_WORDS);
        end
        else
        begin
            keep = {1'b0, in_item.word_index} < words;
        end
    end

    always_comb
    begin
        new_cmd.kind    = bpl_pkg::func_t'(in_item.func);
        new_cmd.first   = in_item.word_index == '0;
        new_cmd.closing = {1'b0, in_item.word_index} == (words - 7'd1);
        new_cmd.row     = in_item.weight_row;
        new_cmd.widx    = in_item.word_index;
        new_cmd.data    = in_item.data_word;
    end

    assign full      = cnt_reg == bpl_pkg::CMD_CW'(bpl_pkg::CMD_DEPTH);
    assign cmd_valid = cnt_reg != '0;
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_wr     = push && !full && keep;
    assign do_rd     = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == bpl_pkg::CMD_PW'(bpl_pkg::CMD_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == bpl_pkg::CMD_PW'(bpl_pkg::CMD_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + bpl_pkg::CMD_CW'(do_wr) - bpl_pkg::CMD_CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- rtl/bpl_outq.sv -----
// ----------------------------------------------------------------------------
// bpl_outq
// Result queue: memory plus a head register that shows the oldest item.
// ----------------------------------------------------------------------------
module bpl_outq #(
    parameter int DEPTH = bpl_pkg::OUT_LIMIT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  bpl_pkg::res_t                   wr_item,
    output logic [$clog2(DEPTH + 1)-1:0]    space,
    output logic                            empty,
    input  logic                            pop,
    output bpl_pkg::res_t                   out_item
);

    localparam int PW = $clog2((DEPTH > 1) ? DEPTH : 2);
    localparam int CW = $clog2(DEPTH + 1);

    bpl_pkg::res_t  mem [DEPTH];
    bpl_pkg::res_t  head_reg;
    logic           head_valid_reg, head_valid_next;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           pop_ok;
    logic           load_head;

    assign pop_ok    = pop && head_valid_reg;
    assign load_head = (cnt_reg != '0) && (!head_valid_reg || pop_ok);
    assign empty     = !head_valid_reg;
    assign out_item  = head_reg;
    assign space     = CW'(DEPTH) - cnt_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (load_head)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(wr_en) - CW'(load_head);
        if (load_head)
        begin
            head_valid_next = 1'b1;
        end
        else if (pop_ok)
        begin
            head_valid_next = 1'b0;
        end
        else
        begin
            head_valid_next = head_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
        if (load_head)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

// ----- rtl/bpl_back.sv -----
// ----------------------------------------------------------------------------
// bpl_back
// Executes queued items: weight loads write the weight store; activation
// words sweep the rows through a three-stage read/popcount/accumulate pipe.
// ----------------------------------------------------------------------------
`include "binary_popcount_linear_macros.svh"

module bpl_back #(
    parameter int MAX_ROWS  = bpl_pkg::MAX_ROWS_DEF,
    parameter int MAX_WORDS = bpl_pkg::MAX_WORDS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [bpl_pkg::K_W-1:0]  k_eff,
    input  logic [bpl_pkg::N_W-1:0]  rows_eff,
    input  logic                     cmd_valid,
    input  bpl_pkg::cmd_t            cmd,
    output logic                     cmd_pop,
    input  logic [$clog2(((MAX_ROWS < bpl_pkg::OUT_LIMIT) ? MAX_ROWS :
                          bpl_pkg::OUT_LIMIT) + 1)-1:0] space,
    output logic                     res_push,
    output bpl_pkg::res_t            res
);

    localparam int ACC_ROWS = (MAX_ROWS < bpl_pkg::OUT_LIMIT) ? MAX_ROWS : bpl_pkg::OUT_LIMIT;
    localparam int RW       = $clog2((ACC_ROWS > 1) ? ACC_ROWS : 2);
    localparam int WD       = MAX_ROWS * MAX_WORDS;
    localparam int WA       = $clog2((WD > 1) ? WD : 2);

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed
    {
        logic          valid;
        logic [RW-1:0] row;
        logic          upd;
        logic          emit;
        logic          last;
    } pipe_t;

    logic [bpl_pkg::WORD_W-1:0]  wmem [WD];
    logic [bpl_pkg::K_W-1:0]     amem [ACC_ROWS];

    state_t                      state_reg, state_next;
    logic [RW-1:0]               row_reg, row_next;
    logic [ACC_ROWS-1:0]         aval_reg, aval_next;
    pipe_t                       p1_reg, p1_next;
    pipe_t                       p2_reg;
    bpl_pkg::cmd_t               cur_reg;
    logic [bpl_pkg::WORD_W-1:0]  mask_reg;
    logic [bpl_pkg::WORD_W-1:0]  w_rd_reg;
    logic [bpl_pkg::K_W-1:0]     acc_rd_reg;
    logic [bpl_pkg::POP_W-1:0]   pop_reg;
    logic [bpl_pkg::K_W-1:0]     base_reg;

    logic                        start_load;
    logic                        start_act;
    logic                        sweep_end;
    logic [WA-1:0]               ld_addr;
    logic [WA-1:0]               rd_addr;
    logic [bpl_pkg::WORD_W-1:0]  mask_new;
    logic [bpl_pkg::K_W-1:0]     base_s1;
    logic [bpl_pkg::POP_W-1:0]   pop_s1;
    logic [bpl_pkg::K_W:0]       sum_s2;
    logic [bpl_pkg::K_W-1:0]     sat_s2;
    logic [bpl_pkg::K_W-1:0]     ham_s2;

    // issue control
    assign start_load = (state_reg == ST_IDLE) && cmd_valid && (cmd.kind == bpl_pkg::FUNC_LOAD);
    assign start_act  = (state_reg == ST_IDLE) && cmd_valid && (cmd.kind == bpl_pkg::FUNC_ACT) &&
                        (!cmd.closing || (space >= rows_eff));
    assign cmd_pop    = start_load || start_act;
    assign sweep_end  = row_reg == RW'(ACC_ROWS - 1);

    assign ld_addr = WA'(WA'(cmd.row) * WA'(MAX_WORDS) + WA'(cmd.widx));
    assign rd_addr = WA'(WA'(row_reg) * WA'(MAX_WORDS) + WA'(cur_reg.widx));

    // padding bits of the closing word never count
    always_comb
    begin
        if (cmd.closing && (k_eff[5:0] != '0))
        begin
            mask_new = (64'd1 << k_eff[5:0]) - 64'd1;
        end
        else
        begin
            mask_new = '1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_act)
                begin
                    state_next = ST_SWEEP;
                    row_next   = '0;
                end
            end
            ST_SWEEP:
            begin
                row_next = row_reg + 1'b1;
                if (sweep_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_reg.valid && !p2_reg.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        p1_next.valid = state_reg == ST_SWEEP;
        p1_next.row   = row_reg;
        p1_next.upd   = 7'(row_reg) < rows_eff;
        p1_next.emit  = cur_reg.closing && (7'(row_reg) < rows_eff);
        p1_next.last  = 7'(row_reg) == (rows_eff - 7'd1);
    end

    // stage 1: popcount and accumulator base (row start clears)
    always_comb
    begin
        pop_s1 = bpl_pkg::popcount64((cur_reg.data ^ w_rd_reg) & mask_reg);
        if (cur_reg.first || !aval_reg[p1_reg.row])
        begin
            base_s1 = '0;
        end
        else
        begin
            base_s1 = acc_rd_reg;
        end
    end

    // stage 2: saturating add, clamp to K, dot product
    always_comb
    begin
        sum_s2 = (bpl_pkg::K_W + 1)'(base_reg) +
                 (bpl_pkg::K_W + 1)'(p2_reg.upd ? pop_reg : '0);
        if (sum_s2 > (bpl_pkg::K_W + 1)'(bpl_pkg::ACC_MAX))
        begin
            sat_s2 = bpl_pkg::K_W'(bpl_pkg::ACC_MAX);
        end
        else
        begin
            sat_s2 = sum_s2[bpl_pkg::K_W-1:0];
        end
        ham_s2 = (sat_s2 > k_eff) ? k_eff : sat_s2;
        aval_next = aval_reg;
        if (p2_reg.valid)
        begin
            aval_next[p2_reg.row] = 1'b1;
        end
    end

    assign res_push      = p2_reg.valid && p2_reg.emit;
    assign res.dot_value = $signed((bpl_pkg::DOT_W)'(k_eff) - {ham_s2, 1'b0});
    assign res.out_row   = bpl_pkg::ROW_W'(p2_reg.row);
    assign res.last      = p2_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            aval_reg  <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            aval_reg  <= aval_next;
            p1_reg    <= p1_next;
            p2_reg    <= p1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_load)
        begin
            wmem[ld_addr] <= cmd.data;
        end
        if (start_act)
        begin
            cur_reg  <= cmd;
            mask_reg <= mask_new;
        end
        if (state_reg == ST_SWEEP)
        begin
            w_rd_reg   <= wmem[rd_addr];
            acc_rd_reg <= amem[row_reg];
        end
        pop_reg  <= pop_s1;
        base_reg <= base_s1;
        if (p2_reg.valid)
        begin
            amem[p2_reg.row] <= sat_s2;
        end
    end

    `BPL_ASSERT(a_push_space, res_push, space != '0)
    `BPL_ASSERT(a_idle_drained, state_reg == ST_IDLE, !p1_reg.valid && !p2_reg.valid)
    `BPL_ASSERT(a_emit_in_use, p2_reg.valid && p2_reg.emit, 7'(p2_reg.row) < rows_eff)
    `BPL_ASSERT_NEXT(a_act_sweeps, start_act, state_reg == ST_SWEEP && row_reg == '0)

endmodule

// ----- rtl/binary_popcount_linear.sv -----
// ----------------------------------------------------------------------------
// binary_popcount_linear
// Binary (+-1) linear layer: XOR/popcount dot products of packed activation
// rows against stored weight rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: push an item while full is low. func = load writes one
//   64-bit weight word at (weight_row, word_index); func = activation
//   carries one word of an activation row, word 0 first.
//   Result queue: while empty is low, out_item holds the oldest result;
//   pop takes it. The closing word of a row yields rows_in_use results,
//   row 0 upward, last set on the final one.
//   Config: cfg_we writes bits_in_use (index 0) or rows_in_use (index 1);
//   write them only while no item is in flight; the block does not enforce it.
//   Flow: the back end takes a load only while idle. An activation word
//   sweeps all min(MAX_ROWS, 64) rows, one weight-store read per row, and
//   the back end takes no new item until that sweep has drained. A
//   2-entry queue separates input acceptance from the row sweep.
//   If the receiver stalls, a closing word waits until the result queue has
//   room for all its results; input keeps flowing until the queue fills.
//   Reset clears accumulators and queues and restores bits_in_use = 4096,
//   rows_in_use = 64; weight words read undefined until written.
// ----------------------------------------------------------------------------
module binary_popcount_linear #(
    parameter int MAX_ROWS  = bpl_pkg::MAX_ROWS_DEF,
    parameter int MAX_WORDS = bpl_pkg::MAX_WORDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  bpl_pkg::in_t               in_item,
    output logic                       empty,
    input  logic                       pop,
    output bpl_pkg::res_t              out_item,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bpl_pkg::CFG_W-1:0]  cfg_data
);

    localparam int ACC_ROWS = (MAX_ROWS < bpl_pkg::OUT_LIMIT) ? MAX_ROWS : bpl_pkg::OUT_LIMIT;
    localparam int K_MAX    = MAX_WORDS * 64;
    localparam int SP_W     = $clog2(ACC_ROWS + 1);

    logic [bpl_pkg::K_W-1:0]  bits_reg, bits_next;
    logic [bpl_pkg::N_W-1:0]  rows_reg, rows_next;
    logic [bpl_pkg::K_W-1:0]  k_eff;
    logic [bpl_pkg::N_W-1:0]  rows_eff;
    logic [bpl_pkg::N_W-1:0]  words;

    logic                     cmd_valid;
    logic                     cmd_pop;
    bpl_pkg::cmd_t            cmd;
    logic [SP_W-1:0]          space;
    logic                     res_push;
    bpl_pkg::res_t            res;

    always_comb
    begin
        bits_next = bits_reg;
        rows_next = rows_reg;
        if (cfg_we)
        begin
            case (bpl_pkg::cfg_reg_t'(cfg_index))
                bpl_pkg::REG_BITS: bits_next = cfg_data[bpl_pkg::K_W-1:0];
                bpl_pkg::REG_ROWS: rows_next = cfg_data[bpl_pkg::N_W-1:0];
                default:           bits_next = bits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= bpl_pkg::K_W'(bpl_pkg::BITS_RESET);
            rows_reg <= bpl_pkg::N_W'(bpl_pkg::ROWS_RESET);
        end
        else
        begin
            bits_reg <= bits_next;
            rows_reg <= rows_next;
        end
    end

    // clamp registers to their legal ranges
    always_comb
    begin
        if (bits_reg == '0)
        begin
            k_eff = bpl_pkg::K_W'(1);
        end
        else if (int'(bits_reg) > K_MAX)
        begin
            k_eff = bpl_pkg::K_W'(K_MAX);
        end
        else
        begin
            k_eff = bits_reg;
        end
        if (rows_reg == '0)
        begin
            rows_eff = bpl_pkg::N_W'(1);
        end
        else if (int'(rows_reg) > ACC_ROWS)
        begin
            rows_eff = bpl_pkg::N_W'(ACC_ROWS);
        end
        else
        begin
            rows_eff = rows_reg;
        end
        words = bpl_pkg::N_W'(((bpl_pkg::K_W + 1)'(k_eff) + (bpl_pkg::K_W + 1)'(63)) >> 6);
    end

    bpl_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .words     (words),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    bpl_back #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .k_eff     (k_eff),
        .rows_eff  (rows_eff),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .space     (space),
        .res_push  (res_push),
        .res       (res)
    );

    bpl_outq #(
        .DEPTH (ACC_ROWS)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_push),
        .wr_item  (res),
        .space    (space),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

// ----- tb/binary_popcount_linear_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_popcount_linear_tb
// Drives weight loads and packed activation rows into the popcount linear
// block, predicts every dot product in the bench, and checks each popped
// result field by field. A short directed table comes first, then mixed random
// rows over many register settings, with random stalls on both queues.
// ----------------------------------------------------------------------------
module binary_popcount_linear_tb;

    localparam int STORE_ROWS   = bpl_pkg::MAX_ROWS_DEF;
    localparam int STORE_WORDS  = bpl_pkg::MAX_WORDS_DEF;
    localparam int PRE_ROWS     = 8;
    localparam int PRE_WORDS    = 4;
    localparam int RAND_BITS    = PRE_WORDS * 64;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_TARGET  = 280;
    localparam int SHOW_LIMIT   = 10;
    localparam int HAMMER_REPS  = 130;

    typedef enum logic
    {
        STEP_CFG  = 1'b0,
        STEP_ITEM = 1'b1
    } step_kind_t;

    typedef struct
    {
        step_kind_t                       kind;
        bpl_pkg::cfg_reg_t                creg;
        logic [bpl_pkg::CFG_W-1:0]        cval;
        bpl_pkg::in_t                     item;
        bit                               typed;
        logic signed [bpl_pkg::DOT_W-1:0] tdot;
    } step_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    bpl_pkg::in_t              in_item;
    logic                      empty;
    logic                      pop;
    bpl_pkg::res_t             out_item;
    logic                      cfg_we;
    logic                      cfg_index;
    logic [bpl_pkg::CFG_W-1:0] cfg_data;

    // bench copy of the block state
    logic [bpl_pkg::WORD_W-1:0] weight_mem [STORE_ROWS][STORE_WORDS];
    int unsigned                ham_count [STORE_ROWS];
    logic [bpl_pkg::K_W-1:0]    bits_reg;
    logic [bpl_pkg::N_W-1:0]    rows_reg;
    bpl_pkg::res_t              dot_queue [$];

    int  errors        = 0;
    int  sent_items    = 0;
    int  live_items    = 0;
    int  results_seen  = 0;
    int  results_due   = 0;
    int  cfg_writes    = 0;
    bit  tx_calm       = 1'b0;
    bit  rx_calm       = 1'b0;

    binary_popcount_linear dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #200000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned eff_bits();
        int unsigned k;
        k = bits_reg;
        if (k < 1)
            k = 1;
        if (k > STORE_WORDS * 64)
            k = STORE_WORDS * 64;
        return k;
    endfunction

    function automatic int unsigned eff_rows();
        int unsigned n;
        int unsigned cap;
        n   = rows_reg;
        cap = (STORE_ROWS < bpl_pkg::OUT_LIMIT) ? STORE_ROWS : bpl_pkg::OUT_LIMIT;
        if (n < 1)
            n = 1;
        if (n > cap)
            n = cap;
        return n;
    endfunction

    function automatic logic [bpl_pkg::WORD_W-1:0] rand_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic bpl_pkg::in_t mk_act(logic [bpl_pkg::IDX_W-1:0] idx,
                                            logic [bpl_pkg::WORD_W-1:0] data);
        bpl_pkg::in_t it;
        it.func       = bpl_pkg::FUNC_ACT;
        it.weight_row = bpl_pkg::ROW_W'($urandom_range(0, 63));
        it.word_index = idx;
        it.data_word  = data;
        return it;
    endfunction

    function automatic bpl_pkg::in_t mk_load(logic [bpl_pkg::ROW_W-1:0] row,
                                             logic [bpl_pkg::IDX_W-1:0] idx,
                                             logic [bpl_pkg::WORD_W-1:0] data);
        bpl_pkg::in_t it;
        it.func       = bpl_pkg::FUNC_LOAD;
        it.weight_row = row;
        it.word_index = idx;
        it.data_word  = data;
        return it;
    endfunction

    function automatic step_t cfg_step(bpl_pkg::cfg_reg_t which, int value);
        step_t s;
        s.kind  = STEP_CFG;
        s.creg  = which;
        s.cval  = bpl_pkg::CFG_W'(value);
        s.item  = '0;
        s.typed = 1'b0;
        s.tdot  = '0;
        return s;
    endfunction

    function automatic step_t item_step(bpl_pkg::in_t it, bit typed, int dot);
        step_t s;
        s.kind  = STEP_ITEM;
        s.creg  = bpl_pkg::REG_BITS;
        s.cval  = '0;
        s.item  = it;
        s.typed = typed;
        s.tdot  = bpl_pkg::DOT_W'(dot);
        return s;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 250);
    endfunction

    // updates the bench state for one accepted item; returns 0 if it is ignored
    function automatic bit predict_dots(bpl_pkg::in_t it, bit typed,
                                        logic signed [bpl_pkg::DOT_W-1:0] tdot);
        int unsigned                k;
        int unsigned                words;
        int unsigned                rows;
        int unsigned                ham;
        int                         dot;
        logic [bpl_pkg::WORD_W-1:0] mask;
        bpl_pkg::res_t              want;
        k     = eff_bits();
        words = (k + 63) / 64;
        rows  = eff_rows();
        if (it.func == bpl_pkg::FUNC_LOAD)
        begin
            weight_mem[it.weight_row][it.word_index] = it.data_word;
            return 1'b1;
        end
        if (it.word_index >= words)
            return 1'b0;
        if (it.word_index == 0)
        begin
            for (int r = 0; r < STORE_ROWS; r++)
            begin
                ham_count[r] = 0;
            end
        end
        mask = '1;
        // padding above K in the closing word never counts
        if (it.word_index == words - 1 && (k % 64) != 0)
            mask = (64'd1 << (k % 64)) - 64'd1;
        for (int r = 0; r < rows; r++)
        begin
            ham_count[r] += $countones((it.data_word ^ weight_mem[r][it.word_index]) & mask);
            if (ham_count[r] > bpl_pkg::ACC_MAX)
                ham_count[r] = bpl_pkg::ACC_MAX;
        end
        if (it.word_index != words - 1)
            return 1'b1;
        for (int r = 0; r < rows; r++)
        begin
            ham = (ham_count[r] > k) ? k : ham_count[r];
            dot = int'(k) - 2 * int'(ham);
            want.dot_value = typed ? tdot : bpl_pkg::DOT_W'(dot);
            want.out_row   = bpl_pkg::ROW_W'(r);
            want.last      = (r == rows - 1);
            dot_queue.push_back(want);
            results_due++;
        end
        return 1'b1;
    endfunction

    task automatic send(bpl_pkg::in_t it, bit typed, logic signed [bpl_pkg::DOT_W-1:0] tdot);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_items++;
        if (predict_dots(it, typed, tdot))
            live_items++;
    endtask

    // sender holds off until every predicted result has been popped
    task automatic wait_idle();
        push <= 1'b0;
        while (dot_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(bpl_pkg::cfg_reg_t which, logic [bpl_pkg::CFG_W-1:0] value);
        cfg_index <= which;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == bpl_pkg::REG_BITS)
            bits_reg = value[bpl_pkg::K_W-1:0];
        else
            rows_reg = value[bpl_pkg::N_W-1:0];
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic play_sequence(int unsigned words);
        int roll;
        int cut;
        roll = $urandom_range(0, 99);
        cut  = $urandom_range(0, words - 1);
        if (roll < 55)
        begin
            for (int w = 0; w < words; w++)
                send(mk_act(bpl_pkg::IDX_W'(w), rand_word()), 1'b0, '0);
        end
        else if (roll < 68)
        begin
            repeat ($urandom_range(1, 4))
                send(mk_load(bpl_pkg::ROW_W'($urandom_range(0, 63)),
                             bpl_pkg::IDX_W'($urandom_range(0, 1) ?
                                             $urandom_range(0, words - 1) :
                                             $urandom_range(0, 63)),
                             rand_word()), 1'b0, '0);
        end
        else if (roll < 74)
        begin
            // row cut short; the next word 0 restarts it
            for (int w = 0; w < cut; w++)
                send(mk_act(bpl_pkg::IDX_W'(w), rand_word()), 1'b0, '0);
        end
        else if (roll < 80)
        begin
            // one word left out
            for (int w = 0; w < words; w++)
                if (w != cut || words == 1)
                    send(mk_act(bpl_pkg::IDX_W'(w), rand_word()), 1'b0, '0);
        end
        else if (roll < 90)
        begin
            send(mk_act(bpl_pkg::IDX_W'($urandom_range(0, 63)), rand_word()), 1'b0, '0);
        end
        else
        begin
            // closing word sent again keeps adding to the counts
            for (int w = 0; w < words; w++)
                send(mk_act(bpl_pkg::IDX_W'(w), rand_word()), 1'b0, '0);
            repeat ($urandom_range(1, 4))
                send(mk_act(bpl_pkg::IDX_W'(words - 1), rand_word()), 1'b0, '0);
        end
    endtask

    // receiver: runs of pops with random stalls between them
    initial
    begin
        int run;
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 12);
            pop <= 1'b1;
            repeat (run) @(posedge clk);
            gap = pick_gap(rx_calm);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic report_bad(string what, bpl_pkg::res_t want, bpl_pkg::res_t got);
        errors++;
        if (errors <= SHOW_LIMIT)
            $display("%0t %s: expected dot %0d row %0d last %0b, got dot %0d row %0d last %0b",
                     $time, what, want.dot_value, want.out_row, want.last,
                     got.dot_value, got.out_row, got.last);
    endtask

    always @(posedge clk)
    begin : result_check
        bpl_pkg::res_t want;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (dot_queue.size() == 0)
            begin
                report_bad("unexpected result", '0, out_item);
            end
            else
            begin
                want = dot_queue.pop_front();
                if (out_item !== want)
                    report_bad("mismatch", want, out_item);
            end
        end
    end

    initial
    begin
        step_t       plan [$];
        int unsigned words;
        int          roll;
        int          bits_val;
        int          rows_val;
        int          phase;

        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = bpl_pkg::REG_BITS;
        cfg_data  = '0;
        bits_reg  = bpl_pkg::K_W'(bpl_pkg::BITS_RESET);
        rows_reg  = bpl_pkg::N_W'(bpl_pkg::ROWS_RESET);
        for (int r = 0; r < STORE_ROWS; r++)
            ham_count[r] = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every weight word that an activation counts gets a value first:
        // the top word of every row, and the low words of the first rows
        tx_calm = 1'b1;
        for (int r = 0; r < STORE_ROWS; r++)
            send(mk_load(bpl_pkg::ROW_W'(r), bpl_pkg::IDX_W'(STORE_WORDS - 1), '0),
                 1'b0, '0);
        for (int r = 0; r < PRE_ROWS; r++)
            for (int w = 0; w < PRE_WORDS; w++)
                send(mk_load(bpl_pkg::ROW_W'(r), bpl_pkg::IDX_W'(w), '0), 1'b0, '0);
        tx_calm = 1'b0;

        // reset settings: K = 4096, 64 rows, counts zero, weights zero
        plan.push_back(item_step(mk_act(6'd63, '0), 1'b1, 4096));
        plan.push_back(item_step(mk_act(6'd63, '1), 1'b1, 3968));
        // zero in both registers clamps to one bit and one row
        plan.push_back(cfg_step(bpl_pkg::REG_BITS, 0));
        plan.push_back(cfg_step(bpl_pkg::REG_ROWS, 0));
        plan.push_back(item_step(mk_act(6'd0, '1), 1'b1, -1));
        plan.push_back(item_step(mk_act(6'd1, '1), 1'b0, 0));
        plan.push_back(item_step(mk_act(6'd0, ~64'd1), 1'b1, 1));
        plan.push_back(item_step(mk_load(6'd0, 6'd0, '1), 1'b0, 0));
        plan.push_back(item_step(mk_act(6'd0, '1), 1'b0, 0));
        plan.push_back(item_step(mk_load(6'd63, 6'd63, '1), 1'b0, 0));
        // all-ones registers clamp to the maximum
        plan.push_back(cfg_step(bpl_pkg::REG_BITS, 8191));
        plan.push_back(cfg_step(bpl_pkg::REG_ROWS, 127));
        plan.push_back(item_step(mk_act(6'd63, '0), 1'b0, 0));
        plan.push_back(cfg_step(bpl_pkg::REG_BITS, 128));
        plan.push_back(cfg_step(bpl_pkg::REG_ROWS, 2));
        plan.push_back(item_step(mk_act(6'd0, '0), 1'b0, 0));
        plan.push_back(item_step(mk_act(6'd1, '1), 1'b0, 0));
        plan.push_back(item_step(mk_act(6'd1, '1), 1'b0, 0));
        plan.push_back(item_step(mk_act(6'd1, '1), 1'b0, 0));
        plan.push_back(cfg_step(bpl_pkg::REG_BITS, 65));
        plan.push_back(item_step(mk_act(6'd0, 64'h0123_4567_89AB_CDEF), 1'b0, 0));
        plan.push_back(item_step(mk_act(6'd1, '1), 1'b0, 0));
        plan.push_back(item_step(mk_load(6'd5, 6'd2, 64'hA5A5_5A5A_F00F_0FF0), 1'b0, 0));
        plan.push_back(cfg_step(bpl_pkg::REG_BITS, 64));
        plan.push_back(cfg_step(bpl_pkg::REG_ROWS, PRE_ROWS));
        plan.push_back(item_step(mk_act(6'd0, '1), 1'b0, 0));

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CFG)
            begin
                wait_idle();
                set_reg(plan[i].creg, plan[i].cval);
            end
            else
            begin
                send(plan[i].item, plan[i].typed, plan[i].tdot);
            end
        end

        phase = 0;
        while (sent_items < ITEM_TARGET)
        begin
            wait_idle();
            if (phase == 0)
            begin
                // long run of repeated closing words drives the counter to saturation
                set_reg(bpl_pkg::REG_BITS, 13'd128);
                set_reg(bpl_pkg::REG_ROWS, 13'd1);
                send(mk_load(6'd0, 6'd0, '0), 1'b0, '0);
                send(mk_load(6'd0, 6'd1, '0), 1'b0, '0);
                send(mk_act(6'd0, '1), 1'b0, '0);
                repeat (HAMMER_REPS)
                    send(mk_act(6'd1, '1), 1'b0, '0);
                wait_idle();
            end

            // settings stay within the weight words written up front
            roll = $urandom_range(0, 99);
            if (roll < 35)
                bits_val = $urandom_range(1, 64);
            else if (roll < 70)
                bits_val = $urandom_range(65, RAND_BITS);
            else if (roll < 88)
            begin
                case ($urandom_range(0, 5))
                    0:       bits_val = 63;
                    1:       bits_val = 64;
                    2:       bits_val = 65;
                    3:       bits_val = 127;
                    4:       bits_val = 128;
                    default: bits_val = 129;
                endcase
            end
            else if (roll < 94)
                bits_val = 0;
            else
                bits_val = RAND_BITS;

            roll = $urandom_range(0, 99);
            if (roll < 80)
                rows_val = $urandom_range(1, PRE_ROWS);
            else if (roll < 90)
                rows_val = 0;
            else
                rows_val = PRE_ROWS;

            if ($urandom_range(0, 3) != 0)
                set_reg(bpl_pkg::REG_BITS, bpl_pkg::CFG_W'(bits_val));
            if ($urandom_range(0, 3) != 0)
                set_reg(bpl_pkg::REG_ROWS, bpl_pkg::CFG_W'(rows_val));

            tx_calm = ($urandom_range(0, 5) == 0);
            rx_calm = ($urandom_range(0, 5) == 0);
            words   = (eff_bits() + 63) / 64;
            repeat ($urandom_range(2, 5))
                play_sequence(words);
            phase++;
        end

        push <= 1'b0;
        while (dot_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items (%0d live) over %0d register writes and %0d phases",
                 sent_items, live_items, cfg_writes, phase);
        $display("popped %0d of %0d predicted results, %0d errors",
                 results_seen, results_due, errors);
        if (errors == 0 && dot_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
